[design/gbc_pkg.sv]
// Shared constants, state codes and types for the biconnectivity checker.
package gbc_pkg;

    localparam int MaxNodes = 16;
    localparam int NodeW    = $clog2(MaxNodes);
    localparam int CntW     = NodeW + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EDGE2 = 3'd1;
    localparam logic [2:0] ST_INIT  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_POP1  = 3'd4;
    localparam logic [2:0] ST_POP2  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    typedef logic [MaxNodes-1:0] row_t;

    typedef struct packed {
        logic             wr_en;
        logic [NodeW-1:0] wr_row;
        logic [NodeW-1:0] wr_col;
        logic             clr;
    } adj_ctrl_t;

endpackage

[design/gbc_adj.sv]
// Adjacency bit matrix: one bit set per cycle, whole-matrix clear, one row read.
module gbc_adj (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gbc_pkg::adj_ctrl_t      ctrl,
    input  logic [gbc_pkg::NodeW-1:0] rd_row,
    output gbc_pkg::row_t           rd_data
);
    import gbc_pkg::*;

    row_t rows_reg [MaxNodes];

    // Set one bit or clear the whole matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxNodes; i++)
                rows_reg[i] <= '0;
        end
        else if (ctrl.clr)
        begin
            for (int i = 0; i < MaxNodes; i++)
                rows_reg[i] <= '0;
        end
        else if (ctrl.wr_en)
        begin
            rows_reg[ctrl.wr_row][ctrl.wr_col] <= 1'b1;
        end
    end

    assign rd_data = rows_reg[rd_row];

endmodule

[design/graph_biconnectivity_check_top.sv]
// Biconnectivity checker: edge loader and sequenced depth-first Tarjan walk.
// Load: an in-range edge item writes row a on accept, then row b (one row per cycle);
// others end on accept; a last item adds the walk, one neighbour test per scan cycle.
// Throughput: one item at a time; busy stays high until the item is finished.
// Result: a one-cycle done beat, not stallable by the receiver.
// Reset: asynchronous active low; matrix and flags clear, node_count returns to 1.
module graph_biconnectivity_check_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [gbc_pkg::NodeW-1:0] node_a,
    input  logic [gbc_pkg::NodeW-1:0] node_b,
    input  logic                      has_edge,
    input  logic                      last,
    output logic                      done,
    output logic                      connected,
    output logic                      biconnected,
    output logic                      range_error,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gbc_pkg::CntW-1:0]  cfg_data
);
    import gbc_pkg::*;

    logic [2:0]       state_reg, state_next;
    logic [CntW-1:0]  node_count_reg;
    logic [CntW-1:0]  n;
    logic [NodeW-1:0] a_reg, b_reg;
    logic             last_reg, err_reg;
    logic [MaxNodes-1:0] visited_reg;
    logic [CntW-1:0]  depth_reg, time_reg, cur_reg, root_kids_reg;
    logic [NodeW-1:0] u_reg, par_u_reg, p_reg;
    logic [CntW-1:0]  low_u_reg;
    logic             cut_reg;
    logic             done_reg, conn_reg, bicon_reg, rerr_reg;

    logic [CntW-1:0]  disc_mem  [MaxNodes];
    logic [CntW-1:0]  low_mem   [MaxNodes];
    logic [NodeW-1:0] par_mem   [MaxNodes];
    logic [CntW-1:0]  cur_mem   [MaxNodes];
    logic [NodeW-1:0] stack_mem [MaxNodes];

    adj_ctrl_t        adj_ctrl;
    row_t             adj_row;
    logic             accept;
    logic [NodeW-1:0] cur_idx, disc_ra;
    logic [CntW-1:0]  disc_rd, time_inc;
    logic             in_range;
    row_t             n_mask;

    // Clamp the node count to one..MaxNodes
    always_comb
    begin
        if (node_count_reg == '0)
            n = CntW'(1);
        else if (node_count_reg > CntW'(MaxNodes))
            n = CntW'(MaxNodes);
        else
            n = node_count_reg;
    end

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    // Take a count only while no item is in flight
    assign cfg_ready = !busy;
    assign in_range  = ({1'b0, node_a} < n) && ({1'b0, node_b} < n);
    assign cur_idx   = cur_reg[NodeW-1:0];
    assign disc_ra   = (state_reg == ST_POP2) ? p_reg : cur_idx;
    assign disc_rd   = disc_mem[disc_ra];
    assign time_inc  = time_reg + CntW'(1);

    always_comb
    begin
        for (int i = 0; i < MaxNodes; i++)
            n_mask[i] = (CntW'(i) < n);
    end

    // Drive the matrix: row a on accept, row b next cycle, clear after the result
    always_comb
    begin
        adj_ctrl.wr_en  = 1'b0;
        adj_ctrl.wr_row = node_a;
        adj_ctrl.wr_col = node_b;
        adj_ctrl.clr    = (state_reg == ST_DONE);
        if (accept && has_edge && in_range)
            adj_ctrl.wr_en = 1'b1;
        else if (state_reg == ST_EDGE2)
        begin
            adj_ctrl.wr_en  = 1'b1;
            adj_ctrl.wr_row = b_reg;
            adj_ctrl.wr_col = a_reg;
        end
    end

    gbc_adj u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (adj_ctrl),
        .rd_row  (u_reg),
        .rd_data (adj_row)
    );

    // Sequence the load and the walk
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_edge && in_range)
                        state_next = ST_EDGE2;
                    else if (last)
                        state_next = ST_INIT;
                end
            end
            ST_EDGE2: state_next = last_reg ? ST_INIT : ST_IDLE;
            ST_INIT:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (cur_reg >= n)
                    state_next = (depth_reg == CntW'(1)) ? ST_DONE : ST_POP1;
            end
            ST_POP1:  state_next = ST_POP2;
            ST_POP2:  state_next = ST_SCAN;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= CntW'(1);
            err_reg        <= 1'b0;
            last_reg       <= 1'b0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            time_reg       <= '0;
            root_kids_reg  <= '0;
            cut_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
            if (cfg_valid && cfg_ready)
                node_count_reg <= cfg_data;
            if (accept)
            begin
                last_reg <= last;
                if (has_edge && !in_range)
                    err_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    visited_reg   <= MaxNodes'(1);
                    depth_reg     <= CntW'(1);
                    time_reg      <= CntW'(1);
                    root_kids_reg <= '0;
                    cut_reg       <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (cur_reg < n && adj_row[cur_idx] && !visited_reg[cur_idx])
                    begin
                        visited_reg[cur_idx] <= 1'b1;
                        depth_reg <= depth_reg + CntW'(1);
                        time_reg  <= time_inc;
                        if (u_reg == '0)
                            root_kids_reg <= root_kids_reg + CntW'(1);
                    end
                    else if (cur_reg >= n)
                    begin
                        depth_reg <= depth_reg - CntW'(1);
                    end
                end
                ST_POP2:
                begin
                    if (p_reg == '0)
                    begin
                        if (root_kids_reg > CntW'(1))
                            cut_reg <= 1'b1;
                    end
                    else if (low_u_reg >= disc_rd)
                    begin
                        cut_reg <= 1'b1;
                    end
                end
                ST_DONE:  err_reg <= 1'b0;
                default:  ;
            endcase
        end
    end

    // Walk datapath and per-node tables
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= node_a;
            b_reg <= node_b;
        end
        unique case (state_reg)
            ST_INIT:
            begin
                u_reg        <= '0;
                par_u_reg    <= '0;
                cur_reg      <= '0;
                low_u_reg    <= CntW'(1);
                disc_mem[0]  <= CntW'(1);
                stack_mem[0] <= '0;
            end
            ST_SCAN:
            begin
                if (cur_reg < n && adj_row[cur_idx])
                begin
                    if (!visited_reg[cur_idx])
                    begin
                        // Descend: park the current node, push the neighbour
                        cur_mem[u_reg]  <= cur_reg + CntW'(1);
                        low_mem[u_reg]  <= low_u_reg;
                        par_mem[cur_idx]  <= u_reg;
                        disc_mem[cur_idx] <= time_inc;
                        stack_mem[depth_reg[NodeW-1:0]] <= cur_idx;
                        u_reg     <= cur_idx;
                        par_u_reg <= u_reg;
                        low_u_reg <= time_inc;
                        cur_reg   <= '0;
                    end
                    else
                    begin
                        // Back edge: lower the low value
                        if ((u_reg == '0 || cur_idx != par_u_reg) && disc_rd < low_u_reg)
                            low_u_reg <= disc_rd;
                        cur_reg <= cur_reg + CntW'(1);
                    end
                end
                else if (cur_reg < n)
                begin
                    cur_reg <= cur_reg + CntW'(1);
                end
            end
            ST_POP1:
            begin
                p_reg <= stack_mem[depth_reg[NodeW-1:0] - NodeW'(1)];
            end
            ST_POP2:
            begin
                // Resume the parent with the child's low folded in
                u_reg     <= p_reg;
                par_u_reg <= par_mem[p_reg];
                cur_reg   <= cur_mem[p_reg];
                low_u_reg <= (low_u_reg < low_mem[p_reg]) ? low_u_reg : low_mem[p_reg];
            end
            default: ;
        endcase
    end

    // Result beat
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            conn_reg  <= ((visited_reg & n_mask) == n_mask);
            bicon_reg <= (n == CntW'(1)) ||
                         (((visited_reg & n_mask) == n_mask) && !cut_reg);
            rerr_reg  <= err_reg;
        end
    end

    assign done        = done_reg;
    assign connected   = conn_reg;
    assign biconnected = bicon_reg;
    assign range_error = rerr_reg;

`ifndef SYNTHESIS
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CntW'(MaxNodes))
        else $error("walk stack overflow");
    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> $past(state_reg) == ST_SCAN)
        else $error("result without finished walk");
    a_bicon_conn: assert property (@(posedge clk) disable iff (!rst_n)
        done && biconnected && !connected |-> $past(n) == CntW'(1))
        else $error("biconnected without connected");
`endif

endmodule
